// ===== design/sis_pkg.sv =====
// Shared types and state codes for the stable index sorter.
package sis_pkg;

	typedef struct packed {
		logic [63:0] sort_key;
		logic        set_end;
	} in_item_t;

	typedef struct packed {
		logic [5:0] source_position;
		logic       rank_last;
		logic       capacity_exceeded;
	} out_item_t;

	localparam logic [0:0] REG_SORT_DESCENDING = 1'd0;
	localparam logic [0:0] REG_KEYS_SIGNED     = 1'd1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD_I,
		ST_SCAN,
		ST_WR,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

endpackage

// ===== design/sis_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/stable_index_sorter.sv =====
// Top level of the stable index sorter: key load, rank counting and result emission.
//
// Keys are loaded one per cycle while busy is low. The item with set_end high
// closes the set; the block then ranks each of the n stored keys by counting,
// over one read of the key memory per cycle, how many keys sort before it;
// these reads share the single read port of the key memory. Results then
// follow, each fetched from the order memory in its own ST_EMIT_RD state and
// then shown for one cycle under result_valid; the receiver cannot stall them.
// Register writes are taken only while busy is low.
// Keys beyond MAX_KEYS are dropped and flagged on every result of the set.
// Only the low six bits of a position appear on source_position.
module stable_index_sorter #(
	parameter int MAX_KEYS  = 64,
	parameter int KEY_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sis_pkg::in_item_t  in_item,
	output logic               result_valid,
	output sis_pkg::out_item_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [0:0]         cfg_data
);

	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_KEYS);

	sis_pkg::state_t state_q, state_next;

	logic          desc_q, signed_q, dropped_q;
	logic [CW-1:0] count_q, i_q, j_q, rank_q;
	logic [KEY_WIDTH-1:0] key_i_q;

	logic                 key_we;
	logic [AW-1:0]        key_waddr, key_raddr;
	logic [KEY_WIDTH-1:0] key_rdata;
	logic                 ord_we;
	logic [AW-1:0]        ord_raddr;
	logic [5:0]           ord_rdata;
	logic [5:0]           ord_wdata;

	logic accept;
	logic [KEY_WIDTH-1:0] va, vb;
	logic ahead;

	assign accept    = start && !busy;
	assign cfg_ready = !busy;

	sis_ram #(.WIDTH(KEY_WIDTH), .DEPTH(MAX_KEYS)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(in_item.sort_key[KEY_WIDTH-1:0]),
		.raddr(key_raddr), .rdata(key_rdata)
	);

	sis_ram #(.WIDTH(6), .DEPTH(MAX_KEYS)) u_order_ram (
		.clk(clk), .we(ord_we), .waddr(rank_q[AW-1:0]), .wdata(ord_wdata),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);

	assign key_we    = accept && (count_q < FULL);
	assign key_waddr = count_q[AW-1:0];
	assign ord_wdata = 6'(i_q);

	// Key memory read address: key i first, then the scan over j.
	always_comb begin
		key_raddr = j_q[AW-1:0];
		if (state_q == sis_pkg::ST_RD_I) begin
			key_raddr = i_q[AW-1:0];
		end
	end
	assign ord_raddr = i_q[AW-1:0];

	// Comparison of the key read at address j-1 (va) against key i (vb).
	always_comb begin
		va = key_rdata;
		vb = key_i_q;
		if (signed_q) begin
			va[KEY_WIDTH-1] = ~va[KEY_WIDTH-1];
			vb[KEY_WIDTH-1] = ~vb[KEY_WIDTH-1];
		end
		priority if (va == vb) begin
			ahead = (j_q - CW'(1)) < i_q;
		end else if (desc_q) begin
			ahead = va > vb;
		end else begin
			ahead = va < vb;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			sis_pkg::ST_LOAD: begin
				if (accept && in_item.set_end) begin
					state_next = sis_pkg::ST_RD_I;
				end
			end
			sis_pkg::ST_RD_I:    state_next = sis_pkg::ST_SCAN;
			sis_pkg::ST_SCAN: begin
				if (j_q == count_q) begin
					state_next = sis_pkg::ST_WR;
				end
			end
			sis_pkg::ST_WR: begin
				if (i_q + CW'(1) == count_q) begin
					state_next = sis_pkg::ST_EMIT_RD;
				end else begin
					state_next = sis_pkg::ST_RD_I;
				end
			end
			sis_pkg::ST_EMIT_RD: state_next = sis_pkg::ST_EMIT;
			sis_pkg::ST_EMIT: begin
				if (i_q + CW'(1) == count_q) begin
					state_next = sis_pkg::ST_LOAD;
				end else begin
					state_next = sis_pkg::ST_EMIT_RD;
				end
			end
			default: state_next = sis_pkg::ST_LOAD;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		busy         = (state_q != sis_pkg::ST_LOAD);
		ord_we       = (state_q == sis_pkg::ST_WR);
		result_valid = (state_q == sis_pkg::ST_EMIT);
		result.source_position   = ord_rdata;
		result.rank_last         = (i_q + CW'(1) == count_q);
		result.capacity_exceeded = dropped_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sis_pkg::ST_LOAD;
			desc_q    <= 1'b0;
			signed_q  <= 1'b0;
			dropped_q <= 1'b0;
			count_q   <= '0;
			i_q       <= '0;
			j_q       <= '0;
			rank_q    <= '0;
			key_i_q   <= '0;
		end else begin
			state_q <= state_next;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					sis_pkg::REG_SORT_DESCENDING: desc_q   <= cfg_data[0];
					sis_pkg::REG_KEYS_SIGNED:     signed_q <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (state_q)
				sis_pkg::ST_LOAD: begin
					i_q <= '0;
					if (accept) begin
						if (count_q < FULL) begin
							count_q <= count_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
					end
				end
				sis_pkg::ST_RD_I: begin
					j_q    <= '0;
					rank_q <= '0;
				end
				sis_pkg::ST_SCAN: begin
					// First cycle latches key i; later cycles compare key j-1.
					if (j_q == '0) begin
						key_i_q <= key_rdata;
					end else if ((j_q - CW'(1)) != i_q && ahead) begin
						rank_q <= rank_q + CW'(1);
					end
					j_q <= j_q + CW'(1);
				end
				sis_pkg::ST_WR: begin
					if (i_q + CW'(1) == count_q) begin
						i_q <= '0;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				sis_pkg::ST_EMIT_RD: ;
				sis_pkg::ST_EMIT: begin
					if (i_q + CW'(1) == count_q) begin
						count_q   <= '0;
						dropped_q <= 1'b0;
					end
					i_q <= i_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

endmodule
